FILE: hdl/evr_pkg.sv
package evr_pkg;

    // Default field widths of the block
    localparam int COORD_DEF = 24;
    localparam int ANGLE_DEF = 12;

    // Trig values are Q1.14; magnitudes run 0..16384
    localparam int TRIG_FRAC = 14;
    localparam int MAG_W     = TRIG_FRAC + 1;
    localparam int TRIG_W    = MAG_W + 1;

    // Rotation chain layout
    localparam int N_AXES      = 3;
    localparam int CELL_STAGES = 3;
    localparam int PIPE_DEPTH  = N_AXES * CELL_STAGES;

    // Sine table generation: pi/2 in Q62 and Taylor series length
    localparam logic [63:0] HALF_PI_Q62   = 64'h6487_ED51_10B4_611A;
    localparam int          SERIES_TERMS  = 14;
    localparam int          ROM_ROUND_POS = 48;

    // (a*b) >> 62 for unsigned Q62 operands whose product stays below 4.0
    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    // Divide a series term by (2k)(2k+1)
    function automatic logic [63:0] series_div(input logic [63:0] term, input int k);
        logic [63:0] q;
        unique case (k)
            1:       q = term / 64'd6;
            2:       q = term / 64'd20;
            3:       q = term / 64'd42;
            4:       q = term / 64'd72;
            5:       q = term / 64'd110;
            6:       q = term / 64'd156;
            7:       q = term / 64'd210;
            8:       q = term / 64'd272;
            9:       q = term / 64'd342;
            10:      q = term / 64'd420;
            11:      q = term / 64'd506;
            12:      q = term / 64'd600;
            13:      q = term / 64'd702;
            default: q = term / 64'd812;
        endcase
        return q;
    endfunction

    // sin(theta) in Q62 for theta in [0, pi/2] given in Q62
    function automatic logic [63:0] sine_q62(input logic [63:0] theta);
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        x2   = mul_q62(theta, theta);
        term = theta;
        sum  = theta;
        for (int k = 1; k <= SERIES_TERMS; k++)
        begin
            term = mul_q62(series_div(term, k), x2);
            if (k[0])
                sum = sum - term;
            else
                sum = sum + term;
        end
        return sum;
    endfunction

endpackage

FILE: hdl/evr_in_if.sv
interface evr_in_if #(
    parameter int COORD_BITS = evr_pkg::COORD_DEF,
    parameter int ANGLE_BITS = evr_pkg::ANGLE_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] in_x;
    logic signed [COORD_BITS-1:0] in_y;
    logic signed [COORD_BITS-1:0] in_z;
    logic        [ANGLE_BITS-1:0] angle_x;
    logic        [ANGLE_BITS-1:0] angle_y;
    logic        [ANGLE_BITS-1:0] angle_z;

    modport source (output valid, in_x, in_y, in_z, angle_x, angle_y, angle_z, input ready);
    modport sink   (input valid, in_x, in_y, in_z, angle_x, angle_y, angle_z, output ready);
endinterface

FILE: hdl/evr_out_if.sv
interface evr_out_if #(
    parameter int COORD_BITS = evr_pkg::COORD_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] out_x;
    logic signed [COORD_BITS-1:0] out_y;
    logic signed [COORD_BITS-1:0] out_z;

    modport source (output valid, out_x, out_y, out_z, input ready);
    modport sink   (input valid, out_x, out_y, out_z, output ready);
endinterface

FILE: hdl/evr_sincos.sv
module evr_sincos #(
    parameter int ANGLE_BITS = evr_pkg::ANGLE_DEF
) (
    input  logic                            clk,
    input  logic                            en,
    input  logic        [ANGLE_BITS-1:0]    angle,
    output logic signed [evr_pkg::TRIG_W-1:0] sin_val,
    output logic signed [evr_pkg::TRIG_W-1:0] cos_val
);
    import evr_pkg::*;

    localparam int AW        = ANGLE_BITS - 1;
    localparam int QUARTER_N = 1 << (ANGLE_BITS - 2);
    localparam int ROM_DEPTH = QUARTER_N + 1;
    localparam logic [AW-1:0] QUARTER_A = AW'(QUARTER_N);

    typedef logic [MAG_W-1:0] rom_t [ROM_DEPTH];

    // Quarter-wave sine table, rounded to Q1.14
    function automatic rom_t build_rom();
        rom_t        rom;
        logic [63:0] step;
        logic [63:0] s;
        step   = HALF_PI_Q62 >> (ANGLE_BITS - 2);
        rom[0] = '0;
        for (int i = 1; i < QUARTER_N; i++)
        begin
            s      = sine_q62(step * 64'(i));
            s      = s + (64'd1 << (ROM_ROUND_POS - 1));
            rom[i] = s[ROM_ROUND_POS +: MAG_W];
        end
        rom[QUARTER_N] = MAG_W'(1) << TRIG_FRAC;
        return rom;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    logic [1:0]          s_quad;
    logic [1:0]          c_quad;
    logic [AW-1:0]       idx;
    logic [AW-1:0]       s_addr;
    logic [AW-1:0]       c_addr;
    logic [MAG_W-1:0]    s_mag_reg;
    logic [MAG_W-1:0]    c_mag_reg;
    logic                s_neg_reg;
    logic                c_neg_reg;
    logic signed [TRIG_W-1:0] s_pos;
    logic signed [TRIG_W-1:0] c_pos;

    // Fold the angle into the first quadrant; cosine is sine a quarter turn on
    assign s_quad = angle[ANGLE_BITS-1 -: 2];
    assign c_quad = s_quad + 2'd1;
    assign idx    = {1'b0, angle[ANGLE_BITS-3:0]};
    assign s_addr = s_quad[0] ? (QUARTER_A - idx) : idx;
    assign c_addr = c_quad[0] ? (QUARTER_A - idx) : idx;

    // Read both table ports
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_mag_reg <= SINE_ROM[s_addr];
            c_mag_reg <= SINE_ROM[c_addr];
            s_neg_reg <= s_quad[1];
            c_neg_reg <= c_quad[1];
        end
    end

    // Apply the quadrant sign
    assign s_pos   = {1'b0, s_mag_reg};
    assign c_pos   = {1'b0, c_mag_reg};
    assign sin_val = s_neg_reg ? -s_pos : s_pos;
    assign cos_val = c_neg_reg ? -c_pos : c_pos;

endmodule

FILE: hdl/evr_cell.sv
module evr_cell #(
    parameter int COORD_BITS = evr_pkg::COORD_DEF,
    parameter int ANGLE_BITS = evr_pkg::ANGLE_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [COORD_BITS-1:0] in_vec [evr_pkg::N_AXES],
    input  logic        [ANGLE_BITS-1:0] in_ang [evr_pkg::N_AXES],
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [COORD_BITS-1:0] out_vec [evr_pkg::N_AXES],
    output logic        [ANGLE_BITS-1:0] out_ang [evr_pkg::N_AXES]
);
    import evr_pkg::*;

    // Rotates the pair (a, b) = (vec[0], vec[1]) by angle ang[0]:
    //   a' = c*a - s*b,  b' = s*a + c*b
    // and hands on (b', vec[2], a') with the angles moved down one place.

    localparam int PW = COORD_BITS + TRIG_W;
    localparam int SW = PW + 1;
    localparam logic signed [SW-1:0] HALF = SW'(1) << (TRIG_FRAC - 1);
    localparam logic signed [SW-1:0] MAXV = {{(SW - COORD_BITS + 1){1'b0}}, {(COORD_BITS - 1){1'b1}}};
    localparam logic signed [SW-1:0] MINV = ~MAXV;

    // Round to nearest with ties up, then clamp to the coordinate range
    function automatic logic signed [COORD_BITS-1:0] round_sat(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] t;
        logic signed [SW-1:0] r;
        t = v + HALF;
        r = t >>> TRIG_FRAC;
        if (r > MAXV)
            r = MAXV;
        else if (r < MINV)
            r = MINV;
        return r[COORD_BITS-1:0];
    endfunction

    logic adv1;
    logic adv2;
    logic adv3;
    logic v1_reg, v1_next;
    logic v2_reg, v2_next;
    logic v3_reg, v3_next;

    logic signed [COORD_BITS-1:0] a1_reg, b1_reg, r1_reg;
    logic        [ANGLE_BITS-1:0] ang1_reg [N_AXES];
    logic signed [TRIG_W-1:0]     sin_val, cos_val;

    logic signed [PW-1:0]         pca_reg, psa_reg, pcb_reg, psb_reg;
    logic signed [COORD_BITS-1:0] r2_reg;
    logic        [ANGLE_BITS-1:0] ang2_reg [N_AXES];

    logic signed [COORD_BITS-1:0] vec3_reg [N_AXES];
    logic        [ANGLE_BITS-1:0] ang3_reg [N_AXES];

    // Advance a stage when it is empty or the one after it moves
    assign adv3     = !v3_reg || out_ready;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1;

    assign v1_next = adv1 ? in_valid : v1_reg;
    assign v2_next = adv2 ? v1_reg   : v2_reg;
    assign v3_next = adv3 ? v2_reg   : v3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    // Stage 1: look up sine and cosine, hold the coordinates
    evr_sincos #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_sincos (
        .clk     (clk),
        .en      (adv1),
        .angle   (in_ang[0]),
        .sin_val (sin_val),
        .cos_val (cos_val)
    );

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            a1_reg      <= in_vec[0];
            b1_reg      <= in_vec[1];
            r1_reg      <= in_vec[2];
            ang1_reg[0] <= in_ang[1];
            ang1_reg[1] <= in_ang[2];
            ang1_reg[2] <= '0;
        end
    end

    // Stage 2: form the four products
    always_ff @(posedge clk)
    begin
        if (adv2)
        begin
            pca_reg  <= PW'(cos_val) * PW'(a1_reg);
            psa_reg  <= PW'(sin_val) * PW'(a1_reg);
            pcb_reg  <= PW'(cos_val) * PW'(b1_reg);
            psb_reg  <= PW'(sin_val) * PW'(b1_reg);
            r2_reg   <= r1_reg;
            ang2_reg <= ang1_reg;
        end
    end

    // Stage 3: sum, round, clamp, and reorder for the next axis
    always_ff @(posedge clk)
    begin
        if (adv3)
        begin
            vec3_reg[0] <= round_sat(SW'(psa_reg) + SW'(pcb_reg));
            vec3_reg[1] <= r2_reg;
            vec3_reg[2] <= round_sat(SW'(pca_reg) - SW'(psb_reg));
            ang3_reg    <= ang2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign out_vec   = vec3_reg;
    assign out_ang   = ang3_reg;

endmodule

FILE: hdl/euler_xyz_vector_rotator.sv
// Channel  | Dir | Payload                                      | Handshake
// ---------+-----+----------------------------------------------+-------------
// in_pt    | in  | in_x, in_y, in_z, angle_x, angle_y, angle_z  | valid/ready
// out_pt   | out | out_x, out_y, out_z                          | valid/ready
//
// One item per cycle sustained while the output is taken; the chain of three
// axis cells each register a table read, a multiply, and a round and clamp.
// rst_n clears only the stage valid bits and the item counter; the sine table is constant logic.
// Each stage moves on when it is empty or its successor moves, so gaps
// collapse and input is refused only when every stage holds an item and the
// output is not taken.
module euler_xyz_vector_rotator #(
    parameter int COORD_BITS = evr_pkg::COORD_DEF,
    parameter int ANGLE_BITS = evr_pkg::ANGLE_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    evr_in_if.sink    in_pt,
    evr_out_if.source out_pt
);
    import evr_pkg::*;

    localparam int CNT_W = $clog2(PIPE_DEPTH + 1);

    logic signed [COORD_BITS-1:0] vec   [N_AXES+1][N_AXES];
    logic        [ANGLE_BITS-1:0] ang   [N_AXES+1][N_AXES];
    logic                         valid [N_AXES+1];
    logic                         ready [N_AXES+1];

    // Enter as (y, z, x) so the first cell turns y and z
    assign vec[0][0] = in_pt.in_y;
    assign vec[0][1] = in_pt.in_z;
    assign vec[0][2] = in_pt.in_x;
    assign ang[0][0] = in_pt.angle_x;
    assign ang[0][1] = in_pt.angle_y;
    assign ang[0][2] = in_pt.angle_z;
    assign valid[0]  = in_pt.valid;
    assign in_pt.ready = ready[0];

    // Chain of rotation cells: X, then Y, then Z
    for (genvar k = 0; k < N_AXES; k++)
    begin : g_cell
        evr_cell #(
            .COORD_BITS (COORD_BITS),
            .ANGLE_BITS (ANGLE_BITS)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (valid[k]),
            .in_ready  (ready[k]),
            .in_vec    (vec[k]),
            .in_ang    (ang[k]),
            .out_valid (valid[k+1]),
            .out_ready (ready[k+1]),
            .out_vec   (vec[k+1]),
            .out_ang   (ang[k+1])
        );
    end

    // Leave as (y, z, x)
    assign out_pt.valid = valid[N_AXES];
    assign ready[N_AXES] = out_pt.ready;
    assign out_pt.out_x = vec[N_AXES][2];
    assign out_pt.out_y = vec[N_AXES][0];
    assign out_pt.out_z = vec[N_AXES][1];

    // Track items inside the chain
    logic             in_acc;
    logic             out_acc;
    logic [CNT_W-1:0] items_reg, items_next;

    assign in_acc     = in_pt.valid && in_pt.ready;
    assign out_acc    = out_pt.valid && out_pt.ready;
    assign items_next = items_reg + CNT_W'(in_acc) - CNT_W'(out_acc);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            items_reg <= '0;
        else
            items_reg <= items_next;
    end

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        items_reg <= CNT_W'(PIPE_DEPTH))
        else $error("more items in flight than pipeline stages");

    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        items_reg == '0 |-> !out_pt.valid)
        else $error("output valid with no item in flight");

    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_pt.ready |-> out_pt.valid && !out_pt.ready)
        else $error("input refused while output side is not blocked");

endmodule
